### rtl/doab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Density overlay alpha blend package
// Shared types, register codes and arithmetic constants of the overlay block.
// ----------------------------------------------------------------------------
package doab_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_GRID_WIDTH   = 3'd2,
    CFG_GRID_HEIGHT  = 3'd3,
    CFG_FORMAT_RGB   = 3'd4
  } cfg_reg_e;

  localparam logic [16:0] Q16_ONE      = 17'd65536;
  localparam logic [14:0] ALPHA_SCALE  = 15'd29491;
  localparam logic [14:0] ALPHA_FLOOR  = 15'd65;
  localparam logic [15:0] DIV10_RECIP  = 16'd52429;
  localparam int          DIV10_SHIFT  = 19;
  localparam logic [11:0] TINT_TENTHS [3] = '{12'd2091, 12'd2295, 12'd2550};

  localparam int NUM_W               = 25;
  localparam int DIV_STEPS_PER_STAGE = 5;
  localparam int DIV_STAGES          = NUM_W / DIV_STEPS_PER_STAGE;

  localparam int MQ_DEPTH  = 4;
  localparam int OFQ_DEPTH = 16;
  localparam int OFQ_CW    = $clog2(OFQ_DEPTH) + 1;

  typedef struct packed {
    logic [12:0] fw;
    logic [12:0] fh;
    logic [12:0] gw;
    logic [12:0] gh;
    logic        passthru;
  } cfg_t;

  typedef struct packed {
    logic        is_wr;
    logic        wr_ok;
    logic [11:0] wr_idx;
    logic [16:0] dens;
    logic        bypass;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } bk_item_t;

  typedef struct packed {
    bk_item_t         it;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
  } mq_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       blended;
  } out_item_t;

  typedef struct packed {
    logic [12:0]      rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_st_t;

  // One restoring division step: bring down the next dividend bit.
  function automatic div_st_t div_step(div_st_t s, logic [12:0] d);
    logic [13:0] r;
    div_st_t     o;
    r     = {s.rem, s.num[NUM_W-1]};
    o.num = {s.num[NUM_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      o.rem = 13'(r - {1'b0, d});
      o.quo = {s.quo[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = r[12:0];
      o.quo = {s.quo[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### rtl/density_overlay_alpha_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Density overlay alpha blend
// Blends RGB pixels toward a fixed tint by a density grid that write items load.
// ----------------------------------------------------------------------------
// The block takes one item per clock and, with the result side popping every
// clock, returns one pixel result per clock in item order. A pixel result
// passes through a small input queue, a five-stage cell divider, the index
// multiply and clamp, the density store read, the opacity multiply and a
// two-stage channel blend, then the output queue. The sustained rate is held
// by the 16-entry output queue, which issue into the pipeline reserves ahead;
// density writes take no result and do not reserve space. The density store
// has no reset and needs no clearing pass; pixels mapping to a cell that was
// never written give unspecified colors.
// Configuration must be written only while no items are outstanding.
module density_overlay_alpha_blend import doab_pkg::*; #(
  parameter int GRID_CELLS    = 4096,
  parameter int MAX_FRAME_DIM = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic                   action_i,
  input  wire logic [11:0]            cell_index_i,
  input  wire logic signed [17:0]     density_value_i,
  input  wire logic [11:0]            pixel_x_i,
  input  wire logic [11:0]            pixel_y_i,
  input  wire logic [7:0]             red_in_i,
  input  wire logic [7:0]             green_in_i,
  input  wire logic [7:0]             blue_in_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [7:0]                  red_out_o,
  output logic [7:0]                  green_out_o,
  output logic [7:0]                  blue_out_o,
  output logic                        was_blended_o
);

  cfg_t              cfg;
  mq_item_t          fe_item;
  mq_item_t          head;
  logic              mq_empty;
  logic              head_pop;
  logic              out_push;
  out_item_t         out_item;
  out_item_t         out_head;
  logic [OFQ_CW-1:0] ofq_cnt;

  doab_front #(
    .GRID_CELLS    (GRID_CELLS),
    .MAX_FRAME_DIM (MAX_FRAME_DIM)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .cell_index_i    (cell_index_i),
    .density_value_i (density_value_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .cfg_o           (cfg),
    .item_o          (fe_item)
  );

  doab_queue #(
    .W     ($bits(mq_item_t)),
    .DEPTH (MQ_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fe_item),
    .full_o  (full),
    .pop_i   (head_pop),
    .data_o  (head),
    .empty_o (mq_empty),
    .count_o ()
  );

  doab_back #(
    .GRID_CELLS (GRID_CELLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .head_i     (head),
    .head_vld_i (!mq_empty),
    .head_pop_o (head_pop),
    .ofq_cnt_i  (ofq_cnt),
    .out_push_o (out_push),
    .out_item_o (out_item)
  );

  doab_queue #(
    .W     ($bits(out_item_t)),
    .DEPTH (OFQ_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (out_head),
    .empty_o (empty),
    .count_o (ofq_cnt)
  );

  assign red_out_o     = out_head.red;
  assign green_out_o   = out_head.green;
  assign blue_out_o    = out_head.blue;
  assign was_blended_o = out_head.blended;

endmodule
`default_nettype wire

### rtl/doab_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overlay item queue
// Small first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
module doab_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [W-1:0]               data_i,
  output logic                            full_o,
  input  wire logic                       pop_i,
  output logic [W-1:0]                    data_o,
  output logic                            empty_o,
  output logic [$clog2(DEPTH):0]          count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/doab_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overlay front end
// Holds the configuration registers and classifies each accepted item.
// ----------------------------------------------------------------------------
module doab_front import doab_pkg::*; #(
  parameter int GRID_CELLS    = 4096,
  parameter int MAX_FRAME_DIM = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   action_i,
  input  wire logic [11:0]            cell_index_i,
  input  wire logic signed [17:0]     density_value_i,
  input  wire logic [11:0]            pixel_x_i,
  input  wire logic [11:0]            pixel_y_i,
  input  wire logic [7:0]             red_in_i,
  input  wire logic [7:0]             green_in_i,
  input  wire logic [7:0]             blue_in_i,
  output cfg_t                        cfg_o,
  output mq_item_t                    item_o
);

  function automatic logic [12:0] frame_dim(logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (32'(v) > MAX_FRAME_DIM) begin
      r = 13'(MAX_FRAME_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [12:0] fw_q, fh_q, gw_q, gh_q;
  logic        rgb_q;
  logic [16:0] dens;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= frame_dim(13'd640);
      fh_q  <= frame_dim(13'd480);
      gw_q  <= 13'd0;
      gh_q  <= 13'd0;
      rgb_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  fw_q  <= frame_dim(cfg_data_i);
        CFG_FRAME_HEIGHT: fh_q  <= frame_dim(cfg_data_i);
        CFG_GRID_WIDTH:   gw_q  <= cfg_data_i;
        CFG_GRID_HEIGHT:  gh_q  <= cfg_data_i;
        CFG_FORMAT_RGB:   rgb_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.fw       = fw_q;
    cfg_o.fh       = fh_q;
    cfg_o.gw       = gw_q;
    cfg_o.gh       = gh_q;
    cfg_o.passthru = !rgb_q || (gw_q == 13'd0) || (gh_q == 13'd0);
  end

  always_comb begin
    if (density_value_i[17]) begin
      dens = 17'd0;
    end else if (density_value_i[16:0] > Q16_ONE) begin
      dens = Q16_ONE;
    end else begin
      dens = density_value_i[16:0];
    end
  end

  always_comb begin
    item_o.it.is_wr  = !action_i;
    item_o.it.wr_ok  = (32'(cell_index_i) < GRID_CELLS);
    item_o.it.wr_idx = cell_index_i;
    item_o.it.dens   = dens;
    item_o.it.bypass = cfg_o.passthru;
    item_o.it.red    = red_in_i;
    item_o.it.green  = green_in_i;
    item_o.it.blue   = blue_in_i;
    item_o.num_x     = NUM_W'(pixel_x_i) * NUM_W'(gw_q);
    item_o.num_y     = NUM_W'(pixel_y_i) * NUM_W'(gh_q);
  end

endmodule
`default_nettype wire

### rtl/doab_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Overlay back end
// Cell mapping divider, density store, opacity and per-channel blend pipeline.
// ----------------------------------------------------------------------------
module doab_back import doab_pkg::*; #(
  parameter int GRID_CELLS = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire mq_item_t          head_i,
  input  wire logic              head_vld_i,
  output logic                   head_pop_o,
  input  wire logic [OFQ_CW-1:0] ofq_cnt_i,
  output logic                   out_push_o,
  output out_item_t              out_item_o
);

  localparam int AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

  logic [OFQ_CW-1:0] inflight_q, inflight_d;
  logic              credit_ok;

  // Divider stages.
  logic     dv_vld_q [DIV_STAGES];
  bk_item_t dv_it_q  [DIV_STAGES];
  div_st_t  dx_q     [DIV_STAGES];
  div_st_t  dy_q     [DIV_STAGES];
  div_st_t  dx_d     [DIV_STAGES];
  div_st_t  dy_d     [DIV_STAGES];

  logic        c_vld_q;
  bk_item_t    c_it_q;
  logic [12:0] col_q, row_q, col_d, row_d;
  logic [12:0] gw_m1, gh_m1;

  logic        m_vld_q;
  bk_item_t    m_it_q;
  logic [25:0] prod_q;
  logic [12:0] mcol_q;

  logic        a_vld_q;
  bk_item_t    a_it_q;
  logic [AW-1:0] addr_q, addr_d;
  logic [26:0] cell_sum;

  logic [16:0] mem [GRID_CELLS];
  logic        r_vld_q;
  bk_item_t    r_it_q;
  logic [16:0] rd_q;

  logic        l_vld_q;
  bk_item_t    l_it_q;
  logic [14:0] alpha_q, alpha_d;
  logic        blend_q;
  logic [31:0] aprod;

  logic        b_vld_q;
  bk_item_t    b_it_q;
  logic        b_blend_q;
  logic [13:0] t_q [3];
  logic [13:0] t_d [3];
  logic [7:0]  pix_l [3];
  logic [7:0]  pix_b [3];
  logic [7:0]  res   [3];
  logic        any_vld;

  assign credit_ok  = ({1'b0, inflight_q} + {1'b0, ofq_cnt_i}) < (OFQ_CW + 1)'(OFQ_DEPTH);
  assign head_pop_o = head_vld_i && (head_i.it.is_wr || credit_ok);

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        dx_d[s] = '{rem: '0, num: head_i.num_x, quo: '0};
        dy_d[s] = '{rem: '0, num: head_i.num_y, quo: '0};
      end else begin
        dx_d[s] = dx_q[s-1];
        dy_d[s] = dy_q[s-1];
      end
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        dx_d[s] = div_step(dx_d[s], cfg_i.fw);
        dy_d[s] = div_step(dy_d[s], cfg_i.fh);
      end
    end
  end

  always_comb begin
    gw_m1 = cfg_i.gw - 13'd1;
    gh_m1 = cfg_i.gh - 13'd1;
    col_d = (dx_q[DIV_STAGES-1].quo > NUM_W'(gw_m1)) ? gw_m1 : dx_q[DIV_STAGES-1].quo[12:0];
    row_d = (dy_q[DIV_STAGES-1].quo > NUM_W'(gh_m1)) ? gh_m1 : dy_q[DIV_STAGES-1].quo[12:0];
  end

  always_comb begin
    cell_sum = 27'(prod_q) + 27'(mcol_q);
    if (m_it_q.is_wr) begin
      addr_d = AW'(m_it_q.wr_idx);
    end else if (32'(cell_sum) > 32'(GRID_CELLS - 1)) begin
      addr_d = AW'(GRID_CELLS - 1);
    end else begin
      addr_d = AW'(cell_sum);
    end
  end

  always_comb begin
    aprod   = {15'd0, rd_q} * {17'd0, ALPHA_SCALE};
    alpha_d = aprod[30:16];
  end

  always_comb begin
    logic [16:0] inv;
    logic [24:0] pp;
    logic [28:0] ten;
    logic [26:0] ta;
    logic [29:0] num;
    logic [29:0] q;
    logic [10:0] qv;
    inv      = Q16_ONE - {2'b0, alpha_q};
    pix_l[0] = l_it_q.red;
    pix_l[1] = l_it_q.green;
    pix_l[2] = l_it_q.blue;
    pix_b[0] = b_it_q.red;
    pix_b[1] = b_it_q.green;
    pix_b[2] = b_it_q.blue;
    for (int c = 0; c < 3; c++) begin
      pp     = 25'(pix_l[c]) * 25'(inv);
      ten    = (29'(pp) << 3) + (29'(pp) << 1);
      ta     = 27'(TINT_TENTHS[c]) * 27'(alpha_q);
      num    = 30'(ten) + 30'(ta);
      t_d[c] = num[29:16];
      q      = 30'(t_q[c]) * 30'(DIV10_RECIP);
      qv     = q[29:DIV10_SHIFT];
      if (!b_blend_q) begin
        res[c] = pix_b[c];
      end else if (qv > 11'd255) begin
        res[c] = 8'd255;
      end else begin
        res[c] = qv[7:0];
      end
    end
  end

  assign out_push_o         = b_vld_q && !b_it_q.is_wr;
  assign out_item_o.red     = res[0];
  assign out_item_o.green   = res[1];
  assign out_item_o.blue    = res[2];
  assign out_item_o.blended = b_blend_q;

  always_comb begin
    inflight_d = inflight_q + OFQ_CW'(head_pop_o && !head_i.it.is_wr) - OFQ_CW'(out_push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_vld_q[s] <= 1'b0;
      end
      c_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      l_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_vld_q[s] <= (s == 0) ? head_pop_o : dv_vld_q[(s == 0) ? 0 : s - 1];
      end
      c_vld_q <= dv_vld_q[DIV_STAGES-1];
      m_vld_q <= c_vld_q;
      a_vld_q <= m_vld_q;
      r_vld_q <= a_vld_q;
      l_vld_q <= r_vld_q;
      b_vld_q <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      dv_it_q[s] <= (s == 0) ? head_i.it : dv_it_q[(s == 0) ? 0 : s - 1];
      dx_q[s]    <= dx_d[s];
      dy_q[s]    <= dy_d[s];
    end
    c_it_q    <= dv_it_q[DIV_STAGES-1];
    col_q     <= col_d;
    row_q     <= row_d;
    m_it_q    <= c_it_q;
    prod_q    <= 26'(row_q) * 26'(cfg_i.gw);
    mcol_q    <= col_q;
    a_it_q    <= m_it_q;
    addr_q    <= addr_d;
    r_it_q    <= a_it_q;
    l_it_q    <= r_it_q;
    alpha_q   <= alpha_d;
    blend_q   <= !r_it_q.bypass && (alpha_d > ALPHA_FLOOR);
    b_it_q    <= l_it_q;
    b_blend_q <= blend_q;
    for (int c = 0; c < 3; c++) begin
      t_q[c] <= t_d[c];
    end
  end

  // Writes and reads meet the store at one stage, in item order.
  always_ff @(posedge clk_i) begin
    if (a_vld_q && a_it_q.is_wr && a_it_q.wr_ok) begin
      mem[addr_q] <= a_it_q.dens;
    end
    rd_q <= mem[addr_q];
  end

  always_comb begin
    any_vld = c_vld_q || m_vld_q || a_vld_q || r_vld_q || l_vld_q || b_vld_q;
    for (int s = 0; s < DIV_STAGES; s++) begin
      any_vld = any_vld || dv_vld_q[s];
    end
  end

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, inflight_q} + {1'b0, ofq_cnt_i}) <= (OFQ_CW + 1)'(OFQ_DEPTH))
    else $error("pixels in flight exceed output queue space");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (ofq_cnt_i < OFQ_CW'(OFQ_DEPTH)))
    else $error("result pushed into a full output queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_vld |-> (inflight_q == '0))
    else $error("in-flight count nonzero with an empty pipeline");

  a_issue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_pop_o && !head_i.it.is_wr) |=> (inflight_q != '0))
    else $error("issued pixel not counted in flight");

endmodule
`default_nettype wire
